// File: design/ssds_pkg.sv
// ----------------------------------------------------------------------------
// ssds_pkg
// Shared types, constants and glyph table for the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssds_pkg;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [2:0] digit_select;
    logic [7:0] segments;
    logic       last;
  } out_item_t;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [2:0]  POS_LAST       = 3'd7;
  localparam logic [2:0]  POS_FIRST_BLANK = 3'd5;
  localparam logic [7:0]  GLYPH_BLANK    = 8'h00;

  // floor(v / 10) == (v * 0xCCCD) >> 19 for all 16-bit v
  localparam logic [15:0] DIV10_RECIP    = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT    = 19;

  function automatic logic [7:0] seg_glyph(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = GLYPH_BLANK;
    endcase
    return pat;
  endfunction

endpackage

// File: design/ssds_queue.sv
// ----------------------------------------------------------------------------
// ssds_queue
// Short item queue between the command front end and the scan sequencer.
// ----------------------------------------------------------------------------
module ssds_queue #(
  parameter int unsigned DEPTH = ssds_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssds_pkg::in_item_t push_item,
  input  logic               pop,
  output ssds_pkg::in_item_t head_item,
  output logic               empty,
  output logic               full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ssds_pkg::in_item_t mem [DEPTH];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CntW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/ssds_back.sv
// ----------------------------------------------------------------------------
// ssds_back
// Scan sequencer: while a scan runs, one decimal digit extracted and one result issued per cycle.
// ----------------------------------------------------------------------------
module ssds_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ssds_pkg::in_item_t  load_item,
  output logic                can_load,
  output logic                out_strobe,
  output ssds_pkg::out_item_t out_data
);

  logic        active_r, active_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] val_r, val_nxt;
  logic [1:0]  chan_r, chan_nxt;

  logic                strobe_r, strobe_nxt;
  ssds_pkg::out_item_t res_r, res_nxt;

  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] rem_wide;
  logic [3:0]  rem;

  assign can_load = !active_r || (pos_r == ssds_pkg::POS_LAST);

  // quotient by reciprocal, remainder by shift-subtract
  assign prod     = val_r * ssds_pkg::DIV10_RECIP;
  assign quot     = prod[31:ssds_pkg::DIV10_SHIFT];
  assign rem_wide = val_r - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign rem      = rem_wide[3:0];

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    chan_nxt   = chan_r;
    strobe_nxt = active_r;
    res_nxt.digit_select = pos_r;
    res_nxt.last         = (pos_r == ssds_pkg::POS_LAST);
    if (pos_r == ssds_pkg::POS_LAST) begin
      res_nxt.segments = ssds_pkg::seg_glyph({2'b00, chan_r} + 4'd1);
    end else if (pos_r >= ssds_pkg::POS_FIRST_BLANK) begin
      res_nxt.segments = ssds_pkg::GLYPH_BLANK;
    end else begin
      res_nxt.segments = ssds_pkg::seg_glyph(rem);
    end

    if (active_r) begin
      pos_nxt = pos_r + 1'b1;
      val_nxt = {3'b000, quot};
      if (pos_r == ssds_pkg::POS_LAST) begin
        active_nxt = 1'b0;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      pos_nxt    = '0;
      val_nxt    = load_item.value;
      chan_nxt   = load_item.channel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    chan_r <= chan_nxt;
    res_r  <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = res_r;

  a_last_on_pos7: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.last == (out_data.digit_select == ssds_pkg::POS_LAST)))
    else $error("last flag out of step with digit position");

  a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |=>
      (out_strobe && out_data.digit_select == $past(out_data.digit_select) + 3'd1))
    else $error("scan broken before position seven");

  a_blank_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.digit_select == 3'd5 || out_data.digit_select == 3'd6))
      |-> (out_data.segments == ssds_pkg::GLYPH_BLANK))
    else $error("blank position lit");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("item loaded mid-scan");

endmodule

// File: design/seven_segment_decimal_scan.sv
// ----------------------------------------------------------------------------
// seven_segment_decimal_scan
// Multiplexed seven-segment driver: one value becomes an eight-position scan.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item yields eight
// results on consecutive cycles, positions 0 to 7, each marked by out_strobe
// for one cycle; from idle, an item passes the queue, the sequencer state and
// the result register before the first appears. Results cannot be held off.
// The scan sequencer, extracting one decimal digit per cycle, sets the
// sustained rate and loads the next item at position 7. A queue of QUEUE_DEPTH
// items ahead of it keeps start open during a scan; busy rises only when full.
module seven_segment_decimal_scan #(
  parameter int unsigned QUEUE_DEPTH = ssds_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ssds_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output ssds_pkg::out_item_t out_data
);

  ssds_pkg::in_item_t head_item;
  logic               q_empty, q_full;
  logic               can_load, load;

  assign busy = q_full;
  assign load = can_load && !q_empty;

  ssds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_item (in_data),
    .pop       (load),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  ssds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_item  (head_item),
    .can_load   (can_load),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
